// ----- rtl/core/clm_pkg.sv -----
package clm_pkg;

    localparam logic [1:0] KIND_ACQ    = 2'd0;
    localparam logic [1:0] KIND_REL    = 2'd1;
    localparam logic [1:0] KIND_REVOKE = 2'd2;
    localparam logic [1:0] KIND_RETRY  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RETRY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_WFULL   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [1:0] MODE_FREE   = 2'd0;
    localparam logic [1:0] MODE_LOCKED = 2'd1;
    localparam logic [1:0] MODE_REVOKE = 2'd2;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // one accepted transaction on its way from front to back
    typedef struct packed {
        logic        action;
        logic [15:0] client_id;
        logic [63:0] lock_id;
        logic [31:0] request_seq;
    } req_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  msg_kind;
        logic [2:0]  status;
        logic [15:0] target_client;
        logic [63:0] target_lock;
        logic [31:0] target_seq;
        logic        last;
    } res_t;

endpackage

// ----- rtl/core/clm_req_queue.sv -----
module clm_req_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  clm_pkg::req_t   push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output clm_pkg::req_t   pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    clm_pkg::req_t     mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]       count_reg;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= inc_ptr(wr_ptr_reg);
            if (pop && not_empty)
                rd_ptr_reg <= inc_ptr(rd_ptr_reg);
            count_reg <= count_reg + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
        end
    end
endmodule

// ----- rtl/core/clm_engine.sv -----
module clm_engine #(
    parameter int LOCK_ENTRIES = 16,
    parameter int WAIT_DEPTH   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  clm_pkg::req_t  req,
    output logic           req_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output clm_pkg::res_t  res
);
    localparam int EW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int SLOTS = LOCK_ENTRIES * WAIT_DEPTH;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_WREAD = 3'd4;
    localparam logic [2:0] S_WOUT  = 3'd5;

    logic [LOCK_ENTRIES-1:0] valid_reg;
    logic [63:0]  key_mem   [LOCK_ENTRIES];
    logic [1:0]   mode_mem  [LOCK_ENTRIES];
    logic [15:0]  oclt_mem  [LOCK_ENTRIES];
    logic [31:0]  oseq_mem  [LOCK_ENTRIES];
    logic [CW-1:0] cnt_mem  [LOCK_ENTRIES];
    logic [15:0]  wclt_mem  [SLOTS];
    logic [31:0]  wseq_mem  [SLOTS];

    logic [2:0]    state_reg;
    clm_pkg::req_t cur_reg;
    logic [EW:0]   scan_reg;
    logic          hit_reg, free_found_reg;
    logic [EW-1:0] hit_idx_reg, free_idx_reg;
    logic [EW-1:0] e_reg;
    logic [15:0]   rev_clt_reg;
    logic [31:0]   rev_seq_reg;
    logic [CW-1:0] wcnt_reg, widx_reg;
    logic [15:0]   wclt_rd_reg;
    logic [31:0]   wseq_rd_reg;
    logic          res_valid_reg;
    clm_pkg::res_t res_reg;

    logic [EW-1:0] sidx;
    logic [SW-1:0] slot_wr, slot_rd;
    logic          res_free;
    logic          res_load;

    assign sidx     = scan_reg[EW-1:0];
    assign res_free = !res_valid_reg || res_ready;
    assign res_load = res_free && (state_reg == S_DEC || state_reg == S_EMIT
                                   || state_reg == S_WOUT);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign req_pop   = (state_reg == S_IDLE) && req_valid;
    assign slot_wr = SW'(e_reg) * SW'(WAIT_DEPTH) + SW'(cnt_mem[e_reg]);
    assign slot_rd = SW'(e_reg) * SW'(WAIT_DEPTH) + SW'(widx_reg);

    function automatic clm_pkg::res_t mk(input logic [1:0] k, input logic [2:0] s,
        input logic [15:0] c, input logic [63:0] l, input logic [31:0] q,
        input logic la);
        clm_pkg::res_t r;
        r.msg_kind = k; r.status = s; r.target_client = c;
        r.target_lock = l; r.target_seq = q; r.last = la;
        return r;
    endfunction

    // table memories (no reset; guarded by valid bits and counts)
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DEC && res_free)
        begin
            if (cur_reg.action == clm_pkg::ACT_ACQUIRE)
            begin
                if (!hit_reg && free_found_reg)
                begin
                    key_mem[free_idx_reg]  <= cur_reg.lock_id;
                    mode_mem[free_idx_reg] <= clm_pkg::MODE_LOCKED;
                    oclt_mem[free_idx_reg] <= cur_reg.client_id;
                    oseq_mem[free_idx_reg] <= cur_reg.request_seq;
                    cnt_mem[free_idx_reg]  <= '0;
                end
                else if (hit_reg)
                begin
                    if (mode_mem[hit_idx_reg] == clm_pkg::MODE_FREE)
                    begin
                        mode_mem[hit_idx_reg] <= clm_pkg::MODE_LOCKED;
                        oclt_mem[hit_idx_reg] <= cur_reg.client_id;
                        oseq_mem[hit_idx_reg] <= cur_reg.request_seq;
                    end
                    else if (cnt_mem[hit_idx_reg] < CW'(WAIT_DEPTH))
                    begin
                        cnt_mem[hit_idx_reg]  <= cnt_mem[hit_idx_reg] + 1'b1;
                        mode_mem[hit_idx_reg] <= clm_pkg::MODE_REVOKE;
                    end
                end
            end
            else if (hit_reg)
            begin
                mode_mem[hit_idx_reg] <= clm_pkg::MODE_FREE;
                cnt_mem[hit_idx_reg]  <= '0;
            end
        end
    end

    // waiter FIFO memory: written in S_DEC, read in S_WREAD
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DEC && res_free && hit_reg
            && cur_reg.action == clm_pkg::ACT_ACQUIRE
            && mode_mem[e_reg] != clm_pkg::MODE_FREE
            && cnt_mem[e_reg] < CW'(WAIT_DEPTH))
        begin
            wclt_mem[slot_wr] <= cur_reg.client_id;
            wseq_mem[slot_wr] <= cur_reg.request_seq;
        end
        if (state_reg == S_WREAD)
        begin
            wclt_rd_reg <= wclt_mem[slot_rd];
            wseq_rd_reg <= wseq_mem[slot_rd];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
            cur_reg <= req;
        if (state_reg == S_SCAN)
        begin
            e_reg <= hit_reg ? hit_idx_reg : free_idx_reg;
        end
        if (state_reg == S_DEC && res_free)
        begin
            rev_clt_reg <= oclt_mem[e_reg];
            rev_seq_reg <= oseq_mem[e_reg];
            wcnt_reg    <= cnt_mem[e_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            scan_reg       <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            hit_idx_reg    <= '0;
            free_idx_reg   <= '0;
            widx_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            res_valid_reg <= res_load || (res_valid_reg && !res_ready);
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg      <= S_SCAN;
                        scan_reg       <= '0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    // one entry per cycle; lowest match and lowest free kept
                    if (scan_reg == (EW+1)'(LOCK_ENTRIES))
                        state_reg <= S_DEC;
                    else
                    begin
                        if (!hit_reg && valid_reg[sidx] && key_mem[sidx] == cur_reg.lock_id)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= sidx;
                        end
                        if (!free_found_reg && !valid_reg[sidx])
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= sidx;
                        end
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_DEC:
                begin
                    if (res_free)
                    begin
                        if (cur_reg.action == clm_pkg::ACT_ACQUIRE)
                        begin
                            if (!hit_reg && !free_found_reg)
                            begin
                                res_reg <= mk(clm_pkg::KIND_ACQ, clm_pkg::ST_FULL,
                                    cur_reg.client_id, cur_reg.lock_id,
                                    cur_reg.request_seq, 1'b1);
                                state_reg <= S_IDLE;
                            end
                            else if (!hit_reg || mode_mem[e_reg] == clm_pkg::MODE_FREE)
                            begin
                                if (!hit_reg)
                                    valid_reg[free_idx_reg] <= 1'b1;
                                res_reg <= mk(clm_pkg::KIND_ACQ, clm_pkg::ST_OK,
                                    cur_reg.client_id, cur_reg.lock_id,
                                    cur_reg.request_seq, 1'b1);
                                state_reg <= S_IDLE;
                            end
                            else if (cnt_mem[e_reg] >= CW'(WAIT_DEPTH))
                            begin
                                res_reg <= mk(clm_pkg::KIND_ACQ, clm_pkg::ST_WFULL,
                                    cur_reg.client_id, cur_reg.lock_id,
                                    cur_reg.request_seq, 1'b1);
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                res_reg <= mk(clm_pkg::KIND_ACQ, clm_pkg::ST_RETRY,
                                    cur_reg.client_id, cur_reg.lock_id,
                                    cur_reg.request_seq,
                                    mode_mem[e_reg] != clm_pkg::MODE_LOCKED);
                                state_reg <= (mode_mem[e_reg] == clm_pkg::MODE_LOCKED)
                                    ? S_EMIT : S_IDLE;
                            end
                        end
                        else if (!hit_reg)
                        begin
                            res_reg <= mk(clm_pkg::KIND_REL, clm_pkg::ST_UNKNOWN,
                                cur_reg.client_id, cur_reg.lock_id,
                                cur_reg.request_seq, 1'b1);
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            res_reg <= mk(clm_pkg::KIND_REL, clm_pkg::ST_OK,
                                cur_reg.client_id, cur_reg.lock_id,
                                cur_reg.request_seq, cnt_mem[e_reg] == '0);
                            widx_reg  <= '0;
                            state_reg <= (cnt_mem[e_reg] != '0) ? S_WREAD : S_IDLE;
                        end
                    end
                end
                S_EMIT:
                begin
                    // revoke to the current owner
                    if (res_free)
                    begin
                        res_reg <= mk(clm_pkg::KIND_REVOKE, clm_pkg::ST_OK, rev_clt_reg,
                            cur_reg.lock_id, rev_seq_reg, 1'b1);
                        state_reg <= S_IDLE;
                    end
                end
                S_WREAD:
                begin
                    state_reg <= S_WOUT;
                end
                S_WOUT:
                begin
                    if (res_free)
                    begin
                        res_reg <= mk(clm_pkg::KIND_RETRY, clm_pkg::ST_OK, wclt_rd_reg,
                            cur_reg.lock_id, wseq_rd_reg, widx_reg + 1'b1 == wcnt_reg);
                        widx_reg  <= widx_reg + 1'b1;
                        state_reg <= (widx_reg + 1'b1 == wcnt_reg) ? S_IDLE : S_WREAD;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/caching_lock_manager_core.sv -----
// Flow: the queue holds each input transaction until the back end takes it; the
//   back end takes one at a time, scans the table one entry per cycle, decides,
//   then registers a result; a revoke or a release with waiters adds results.
// Reset: rst_n asynchronous, active low; clears all valid bits, the queue and
//   the sequencer. Table payload is not cleared and needs no clearing pass.
module caching_lock_manager_core #(
    parameter int LOCK_ENTRIES = 16,
    parameter int WAIT_DEPTH   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [15:0] client_id,
    input  logic [63:0] lock_id,
    input  logic [31:0] request_seq,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  msg_kind,
    output logic [2:0]  status,
    output logic [15:0] target_client,
    output logic [63:0] target_lock,
    output logic [31:0] target_seq,
    output logic        last
);
    // Front end: capture each input transaction into a small queue.
    clm_pkg::req_t in_req, q_req;
    logic          q_full, q_ne, q_pop;
    clm_pkg::res_t res;

    assign in_req.action      = action;
    assign in_req.client_id   = client_id;
    assign in_req.lock_id     = lock_id;
    assign in_req.request_seq = request_seq;
    assign in_ready = !q_full;

    clm_req_queue #(.DEPTH(2)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (in_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_ne),
        .pop_data  (q_req)
    );

    // Back end: table lookup, update and result sequencing.
    clm_engine #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .WAIT_DEPTH   (WAIT_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (q_ne),
        .req       (q_req),
        .req_pop   (q_pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign msg_kind      = res.msg_kind;
    assign status        = res.status;
    assign target_client = res.target_client;
    assign target_lock   = res.target_lock;
    assign target_seq    = res.target_seq;
    assign last          = res.last;

`ifndef ASSERT_OFF
    // a revoke or retry message is never a reply status other than ok
    a_msg_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (msg_kind == clm_pkg::KIND_REVOKE || msg_kind == clm_pkg::KIND_RETRY)
        |-> status == clm_pkg::ST_OK)
        else $error("message with nonzero status");
    // error statuses end a run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == clm_pkg::ST_FULL || status == clm_pkg::ST_WFULL
        || status == clm_pkg::ST_UNKNOWN) |-> last)
        else $error("error status not last");
    // a full queue never claims ready
    a_q_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_ready)
        else $error("ready while queue full");
`endif
endmodule
